// ----- src/bmpg_pkg.sv -----
package bmpg_pkg;

    localparam int GRID_MAX = 8;
    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int DIM_W = 4;
    localparam int IDX_W = 3;
    localparam int SHIFT_W = 6;
    localparam int GRID_SIZE_DEFAULT = 8;

    typedef logic [CELLS-1:0] bitmap_t;

    typedef struct packed {
        bitmap_t base;
        logic    blank;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } dims_t;

    typedef struct packed {
        bitmap_t          pose_bitmap;
        logic [DIM_W-1:0] pose_width;
        logic [DIM_W-1:0] pose_height;
        logic             flipped;
        logic [IDX_W-1:0] pose_index;
        logic             last_pose;
    } result_t;

    function automatic bitmap_t grid_mask(bitmap_t b, int g);
        bitmap_t r;
        r = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            if (i < g * g)
            begin
                r[i] = b[i];
            end
        end
        return r;
    endfunction

    function automatic bitmap_t rotate_ccw(bitmap_t b, int g);
        bitmap_t r;
        r = '0;
        for (int y = 0; y < GRID_MAX; y++)
        begin
            for (int x = 0; x < GRID_MAX; x++)
            begin
                if (y < g && x < g)
                begin
                    r[y * g + x] = b[x * g + g - 1 - y];
                end
            end
        end
        return r;
    endfunction

    function automatic bitmap_t mirror_diag(bitmap_t b, int g);
        bitmap_t r;
        r = '0;
        for (int y = 0; y < GRID_MAX; y++)
        begin
            for (int x = 0; x < GRID_MAX; x++)
            begin
                if (y < g && x < g)
                begin
                    r[y * g + x] = b[x * g + y];
                end
            end
        end
        return r;
    endfunction

    // A normalized shift is a plain right shift by the index of the top-left
    // corner of the bounding box.
    function automatic bitmap_t to_corner(bitmap_t b, int g);
        logic [GRID_MAX-1:0] row_occ;
        logic [GRID_MAX-1:0] col_occ;
        int                  my;
        int                  mx;
        logic [SHIFT_W-1:0]  sh;
        row_occ = '0;
        col_occ = '0;
        for (int y = 0; y < GRID_MAX; y++)
        begin
            for (int x = 0; x < GRID_MAX; x++)
            begin
                if (y < g && x < g && b[y * g + x])
                begin
                    row_occ[y] = 1'b1;
                    col_occ[x] = 1'b1;
                end
            end
        end
        my = 0;
        mx = 0;
        for (int i = GRID_MAX - 1; i >= 0; i--)
        begin
            if (row_occ[i])
            begin
                my = i;
            end
            if (col_occ[i])
            begin
                mx = i;
            end
        end
        sh = SHIFT_W'(my * g + mx);
        return b >> sh;
    endfunction

    function automatic dims_t pose_extent(bitmap_t b, int g);
        dims_t d;
        d.w = '0;
        d.h = '0;
        for (int y = 0; y < GRID_MAX; y++)
        begin
            for (int x = 0; x < GRID_MAX; x++)
            begin
                if (y < g && x < g && b[y * g + x])
                begin
                    if (DIM_W'(x + 1) > d.w)
                    begin
                        d.w = DIM_W'(x + 1);
                    end
                    if (DIM_W'(y + 1) > d.h)
                    begin
                        d.h = DIM_W'(y + 1);
                    end
                end
            end
        end
        return d;
    endfunction

endpackage

// ----- src/bmpg_front.sv -----
module bmpg_front #(
    parameter int GRID_SIZE = bmpg_pkg::GRID_SIZE_DEFAULT
) (
    input  bmpg_pkg::bitmap_t pattern,
    output bmpg_pkg::item_t   item
);

    bmpg_pkg::bitmap_t masked;
    bmpg_pkg::bitmap_t base;

    always_comb
    begin
        masked = bmpg_pkg::grid_mask(pattern, GRID_SIZE);
        base = bmpg_pkg::to_corner(masked, GRID_SIZE);
        item.base = base;
        item.blank = (base == '0);
    end

endmodule

// ----- src/bmpg_queue.sv -----
module bmpg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bmpg_pkg::item_t wr_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output bmpg_pkg::item_t rd_item
);

    bmpg_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_push;
    logic            do_pop;

    assign full = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign rd_item = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- src/bmpg_back.sv -----
module bmpg_back #(
    parameter int GRID_SIZE = bmpg_pkg::GRID_SIZE_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  bmpg_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              res_valid,
    output bmpg_pkg::result_t res,
    input  logic              res_pop
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           face_reg;
    logic                           face_next;
    logic                           blank_reg;
    logic                           blank_next;
    bmpg_pkg::bitmap_t              cur_reg;
    bmpg_pkg::bitmap_t              cur_next;
    bmpg_pkg::bitmap_t              ref_reg;
    bmpg_pkg::bitmap_t              ref_next;
    logic [bmpg_pkg::IDX_W-1:0]     idx_reg;
    logic [bmpg_pkg::IDX_W-1:0]     idx_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    bmpg_pkg::result_t              out_reg;
    bmpg_pkg::result_t              out_next;

    bmpg_pkg::bitmap_t              nxt_rot;
    bmpg_pkg::bitmap_t              flip_ref;
    bmpg_pkg::bitmap_t              flip_start;
    bmpg_pkg::dims_t                dims;
    logic                           emit;
    logic                           is_last;
    logic                           load;

    assign res_valid = out_valid_reg;
    assign res = out_reg;
    assign q_pop = load;

    // Each face is a cyclic rotation orbit, so a face ends as soon as the
    // sequence comes back to the first pose of that face.
    always_comb
    begin
        nxt_rot = bmpg_pkg::to_corner(bmpg_pkg::rotate_ccw(cur_reg, GRID_SIZE), GRID_SIZE);
        flip_ref = bmpg_pkg::mirror_diag(ref_reg, GRID_SIZE);
        flip_start = bmpg_pkg::to_corner(bmpg_pkg::rotate_ccw(flip_ref, GRID_SIZE), GRID_SIZE);
        dims = bmpg_pkg::pose_extent(cur_reg, GRID_SIZE);
        emit = busy_reg && (!out_valid_reg || res_pop);
        is_last = blank_reg || (face_reg && (cur_reg == ref_reg));
        load = q_valid && (!busy_reg || (emit && is_last));

        busy_next = busy_reg;
        face_next = face_reg;
        blank_next = blank_reg;
        cur_next = cur_reg;
        ref_next = ref_reg;
        idx_next = idx_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !res_pop;

        if (emit)
        begin
            out_next.pose_bitmap = cur_reg;
            out_next.pose_width = dims.w;
            out_next.pose_height = dims.h;
            out_next.flipped = face_reg;
            out_next.pose_index = idx_reg;
            out_next.last_pose = is_last;
            out_valid_next = 1'b1;
            idx_next = idx_reg + {{(bmpg_pkg::IDX_W-1){1'b0}}, 1'b1};
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else if (!face_reg && (nxt_rot == ref_reg))
            begin
                face_next = 1'b1;
                cur_next = flip_start;
                ref_next = flip_ref;
            end
            else
            begin
                cur_next = nxt_rot;
            end
        end

        if (load)
        begin
            busy_next = 1'b1;
            face_next = 1'b0;
            blank_next = q_item.blank;
            cur_next = q_item.base;
            ref_next = q_item.base;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg <= face_next;
        blank_reg <= blank_next;
        cur_reg <= cur_next;
        ref_reg <= ref_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

endmodule

// ----- src/bit_matrix_pose_generator_core.sv -----
// Pose generator for one piece pattern on a square grid of up to 8x8 cells.
// The input side is a queue: a 64-bit pattern is taken as a transaction when
// push is high and full is low. The pattern is moved to the upper-left
// corner and placed in a two-entry queue.
// The result side is a one-entry register: while empty is low the pose is on
// the result ports, and it leaves when pop is high. Each pattern gives the
// distinct face-up rotations, then the distinct flipped rotations, with
// last_pose set on the final one; an empty pattern gives one all-zero pose.
// The back end emits one pose per cycle while the receiver pops, and a
// pattern gives 1 to 8 distinct poses; that emission loop sets the throughput.
// A pattern passes the queue, the back end and the result register in turn.
// When the receiver stalls, the result register holds, the back end stops,
// and full rises once the two-entry queue is occupied.
// Reset empties the queue, the back end and the result register; no other state is kept.
module bit_matrix_pose_generator_core #(
    parameter int GRID_SIZE = bmpg_pkg::GRID_SIZE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [bmpg_pkg::CELLS-1:0]      pattern,
    output logic                            empty,
    input  logic                            pop,
    output logic [bmpg_pkg::CELLS-1:0]      pose_bitmap,
    output logic [bmpg_pkg::DIM_W-1:0]      pose_width,
    output logic [bmpg_pkg::DIM_W-1:0]      pose_height,
    output logic                            flipped,
    output logic [bmpg_pkg::IDX_W-1:0]      pose_index,
    output logic                            last_pose
);

    bmpg_pkg::item_t   front_item;
    bmpg_pkg::item_t   q_item;
    logic              q_valid;
    logic              q_pop;
    logic              res_valid;
    bmpg_pkg::result_t res;

    bmpg_front #(
        .GRID_SIZE(GRID_SIZE)
    ) u_front (
        .pattern(pattern),
        .item(front_item)
    );

    bmpg_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .wr_item(front_item),
        .full(full),
        .pop(q_pop),
        .valid(q_valid),
        .rd_item(q_item)
    );

    bmpg_back #(
        .GRID_SIZE(GRID_SIZE)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_pop(q_pop),
        .res_valid(res_valid),
        .res(res),
        .res_pop(pop)
    );

    assign empty = !res_valid;
    assign pose_bitmap = res.pose_bitmap;
    assign pose_width = res.pose_width;
    assign pose_height = res.pose_height;
    assign flipped = res.flipped;
    assign pose_index = res.pose_index;
    assign last_pose = res.last_pose;

    a_flip_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(flipped && (pose_index == '0)))
        else $error("flipped pose shown as the first pose of a pattern");

    a_blank_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (pose_bitmap == '0)) |-> (last_pose && (pose_index == '0)
            && (pose_width == '0) && (pose_height == '0) && !flipped))
        else $error("empty pose is not a single final result");

    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (pose_bitmap != '0)) |-> ((|pose_bitmap[GRID_SIZE-1:0])
            && (pose_width != '0) && (pose_height != '0)))
        else $error("pose is not moved to the top row");

endmodule

// ----- tb/bit_matrix_pose_generator_core_checker.sv -----
module bit_matrix_pose_generator_core_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [bmpg_pkg::CELLS-1:0] pattern,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [bmpg_pkg::CELLS-1:0] pose_bitmap,
    input  logic [bmpg_pkg::DIM_W-1:0] pose_width,
    input  logic [bmpg_pkg::DIM_W-1:0] pose_height,
    input  logic                       flipped,
    input  logic [bmpg_pkg::IDX_W-1:0] pose_index,
    input  logic                       last_pose,
    output int                         mismatches,
    output int                         outstanding
);

    localparam int GRID = bmpg_pkg::GRID_SIZE_DEFAULT;

    bmpg_pkg::result_t pose_q[$];

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    function automatic bmpg_pkg::bitmap_t corner_of(bmpg_pkg::bitmap_t b);
        int              top;
        int              left;
        bmpg_pkg::bitmap_t r;
        top = GRID;
        left = GRID;
        r = '0;
        for (int y = 0; y < GRID; y++)
        begin
            for (int x = 0; x < GRID; x++)
            begin
                if (b[y * GRID + x])
                begin
                    if (y < top)
                    begin
                        top = y;
                    end
                    if (x < left)
                    begin
                        left = x;
                    end
                end
            end
        end
        if (top == GRID)
        begin
            return '0;
        end
        for (int y = top; y < GRID; y++)
        begin
            for (int x = left; x < GRID; x++)
            begin
                if (b[y * GRID + x])
                begin
                    r[(y - top) * GRID + (x - left)] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic void predict_poses(bmpg_pkg::bitmap_t pat);
        bmpg_pkg::bitmap_t shapes[8];
        logic              faces[8];
        int                count;
        bmpg_pkg::bitmap_t cur;
        bmpg_pkg::bitmap_t turned;
        logic              seen;
        logic [3:0]        w;
        logic [3:0]        h;
        bmpg_pkg::result_t r;
        cur = corner_of(pat);
        r = '0;
        if (cur == '0)
        begin
            r.last_pose = 1'b1;
            pose_q.push_back(r);
            return;
        end
        shapes[0] = cur;
        faces[0] = 1'b0;
        count = 1;
        for (int face = 0; face < 2; face++)
        begin
            cur = shapes[0];
            if (face == 1)
            begin
                turned = '0;
                for (int y = 0; y < GRID; y++)
                begin
                    for (int x = 0; x < GRID; x++)
                    begin
                        turned[y * GRID + x] = shapes[0][x * GRID + y];
                    end
                end
                cur = turned;
            end
            for (int i = 0; i < 4; i++)
            begin
                turned = '0;
                for (int y = 0; y < GRID; y++)
                begin
                    for (int x = 0; x < GRID; x++)
                    begin
                        turned[y * GRID + x] = cur[x * GRID + GRID - 1 - y];
                    end
                end
                cur = corner_of(turned);
                seen = 1'b0;
                for (int j = 0; j < count; j++)
                begin
                    if (faces[j] == 1'(face) && shapes[j] == cur)
                    begin
                        seen = 1'b1;
                    end
                end
                if (!seen && count < 8)
                begin
                    shapes[count] = cur;
                    faces[count] = 1'(face);
                    count++;
                end
            end
        end
        for (int k = 0; k < count; k++)
        begin
            w = '0;
            h = '0;
            for (int y = 0; y < GRID; y++)
            begin
                for (int x = 0; x < GRID; x++)
                begin
                    if (shapes[k][y * GRID + x])
                    begin
                        if (4'(x + 1) > w)
                        begin
                            w = 4'(x + 1);
                        end
                        if (4'(y + 1) > h)
                        begin
                            h = 4'(y + 1);
                        end
                    end
                end
            end
            r.pose_bitmap = shapes[k];
            r.pose_width = w;
            r.pose_height = h;
            r.flipped = faces[k];
            r.pose_index = 3'(k);
            r.last_pose = (k == count - 1);
            pose_q.push_back(r);
        end
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        bmpg_pkg::result_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_poses(pattern);
            end
            if (pop && !empty)
            begin
                if (pose_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, pose_bitmap);
                    mismatches++;
                end
                else
                begin
                    want = pose_q.pop_front();
                    compare_field("pose_bitmap", want.pose_bitmap, pose_bitmap);
                    compare_field("pose_width", 64'(want.pose_width), 64'(pose_width));
                    compare_field("pose_height", 64'(want.pose_height), 64'(pose_height));
                    compare_field("flipped", 64'(want.flipped), 64'(flipped));
                    compare_field("pose_index", 64'(want.pose_index), 64'(pose_index));
                    compare_field("last_pose", 64'(want.last_pose), 64'(last_pose));
                end
            end
            outstanding = pose_q.size();
        end
    end

endmodule

// ----- tb/bit_matrix_pose_generator_core_tb.sv -----
module bit_matrix_pose_generator_core_tb;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 260;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic [bmpg_pkg::CELLS-1:0] pattern;
    logic                       empty;
    logic                       pop;
    logic [bmpg_pkg::CELLS-1:0] pose_bitmap;
    logic [bmpg_pkg::DIM_W-1:0] pose_width;
    logic [bmpg_pkg::DIM_W-1:0] pose_height;
    logic                       flipped;
    logic [bmpg_pkg::IDX_W-1:0] pose_index;
    logic                       last_pose;
    int                         mismatches;
    int                         outstanding;
    int                         quiet_cycles;
    logic                       calm;

    bit_matrix_pose_generator_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pattern     (pattern),
        .empty       (empty),
        .pop         (pop),
        .pose_bitmap (pose_bitmap),
        .pose_width  (pose_width),
        .pose_height (pose_height),
        .flipped     (flipped),
        .pose_index  (pose_index),
        .last_pose   (last_pose)
    );

    bit_matrix_pose_generator_core_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pattern     (pattern),
        .empty       (empty),
        .pop         (pop),
        .pose_bitmap (pose_bitmap),
        .pose_width  (pose_width),
        .pose_height (pose_height),
        .flipped     (flipped),
        .pose_index  (pose_index),
        .last_pose   (last_pose),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** bit_matrix_pose_generator_core: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
        end
    end

    task automatic send_pattern(input logic [63:0] p);
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        pattern <= p;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic [63:0] shape;
        int          kind;
        int          cy;
        int          cx;
        int          bw;
        int          bh;
        int          steps;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        pattern = '0;
        calm = 1'b0;
        quiet_cycles = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pattern(64'h0);
        send_pattern(64'hFFFF_FFFF_FFFF_FFFF);
        send_pattern(64'h1);
        send_pattern(64'h8000_0000_0000_0000);
        send_pattern(64'h80);
        send_pattern(64'h0100_0000_0000_0000);
        send_pattern(64'h303 << 27);
        send_pattern(64'hF0 << 56);
        send_pattern(64'h8080_8080_8080_8080);
        send_pattern(64'hFF);
        send_pattern(64'h0101_0101_0101_0101);
        send_pattern(64'h30101 << 26);
        send_pattern(64'h306 << 40);
        send_pattern(64'h207 << 12);
        send_pattern(64'h20306 << 33);
        send_pattern(64'hAA55_AA55_AA55_AA55);
        send_pattern(64'h55AA_55AA_55AA_55AA);
        send_pattern(64'h8040_2010_0804_0201);
        send_pattern(64'h0102_0408_1020_4080);
        send_pattern(64'hF << 60);
        send_pattern({$urandom, $urandom});

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 120 && n < 180);
            kind = $urandom_range(0, 9);
            shape = '0;
            if (kind < 4)
            begin
                cy = $urandom_range(0, 7);
                cx = $urandom_range(0, 7);
                steps = $urandom_range(0, 10);
                shape[cy * 8 + cx] = 1'b1;
                for (int s = 0; s < steps; s++)
                begin
                    case ($urandom_range(0, 3))
                        0: cy = (cy > 0) ? cy - 1 : cy + 1;
                        1: cy = (cy < 7) ? cy + 1 : cy - 1;
                        2: cx = (cx > 0) ? cx - 1 : cx + 1;
                        default: cx = (cx < 7) ? cx + 1 : cx - 1;
                    endcase
                    shape[cy * 8 + cx] = 1'b1;
                end
            end
            else if (kind < 7)
            begin
                bw = $urandom_range(1, 8);
                bh = $urandom_range(1, 8);
                cy = $urandom_range(0, 8 - bh);
                cx = $urandom_range(0, 8 - bw);
                for (int y = 0; y < bh; y++)
                begin
                    for (int x = 0; x < bw; x++)
                    begin
                        shape[(cy + y) * 8 + cx + x] = 1'($urandom_range(0, 1));
                    end
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: shape = {$urandom, $urandom} & {$urandom, $urandom};
                    1: shape = {$urandom, $urandom} | {$urandom, $urandom};
                    default: shape = {$urandom, $urandom};
                endcase
            end
            send_pattern(shape);
        end
        calm = 1'b0;
        push <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("** bit_matrix_pose_generator_core: PASSED **");
        end
        else
        begin
            $display("** bit_matrix_pose_generator_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/bmpg_pkg.sv
src/bmpg_front.sv
src/bmpg_queue.sv
src/bmpg_back.sv
src/bit_matrix_pose_generator_core.sv
tb/bit_matrix_pose_generator_core_checker.sv
tb/bit_matrix_pose_generator_core_tb.sv
